// File: sv/lls_pkg.sv
// ----------------------------------------------------------------------------
// lls_pkg
// Types, token kinds, character codes and keyword table of the Lox scanner.
// ----------------------------------------------------------------------------
package lls_pkg;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic        end_of_tokens;
  } out_item_t;

  localparam int unsigned MaxResults = 4;

  // all results caused by one source byte
  typedef struct packed {
    out_item_t [MaxResults-1:0] items;
    logic [2:0]                 count;
  } batch_t;

  localparam logic [5:0] K_DOT      = 6'd5;
  localparam logic [5:0] K_SLASH    = 6'd9;
  localparam logic [5:0] K_BANG     = 6'd11;
  localparam logic [5:0] K_EQUAL    = 6'd13;
  localparam logic [5:0] K_GREATER  = 6'd15;
  localparam logic [5:0] K_LESS     = 6'd17;
  localparam logic [5:0] K_IDENT    = 6'd19;
  localparam logic [5:0] K_STRING   = 6'd20;
  localparam logic [5:0] K_NUMBER   = 6'd21;
  localparam logic [5:0] K_KEYWORD0 = 6'd22;
  localparam logic [5:0] K_END      = 6'd38;
  localparam logic [5:0] K_BADCHAR  = 6'd39;
  localparam logic [5:0] K_UNTERM   = 6'd40;

  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_LESS    = 8'h3C;
  localparam logic [7:0] CH_GREATER = 8'h3E;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_QUOTE   = 8'h22;

  // keywords packed first char highest, right aligned
  localparam logic [63:0] KW_TEXT [16] = '{
    64'h616E64,       64'h636C617373,   64'h656C7365,   64'h66616C7365,
    64'h66756E,       64'h666F72,       64'h6966,       64'h6E696C,
    64'h6F72,         64'h7072696E74,   64'h72657475726E, 64'h7375706572,
    64'h74686973,     64'h74727565,     64'h766172,     64'h7768696C65
  };

  function automatic logic digit_char(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic alpha_char(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == 8'h5F);
  endfunction

  // parallel compare against all keywords
  function automatic logic [5:0] kw_kind(input logic [63:0] w);
    logic [5:0] k;
    k = K_IDENT;
    for (int i = 0; i < 16; i++) begin
      if (w == KW_TEXT[i]) k = K_KEYWORD0 + 6'(i);
    end
    return k;
  endfunction

  // {hit, kind} for tokens that are complete in one character
  function automatic logic [6:0] single_kind(input logic [7:0] c);
    logic [6:0] r;
    unique case (c)
      CH_LPAREN: r = {1'b1, 6'd0};
      CH_RPAREN: r = {1'b1, 6'd1};
      CH_LBRACE: r = {1'b1, 6'd2};
      CH_RBRACE: r = {1'b1, 6'd3};
      CH_COMMA:  r = {1'b1, 6'd4};
      CH_DOT:    r = {1'b1, K_DOT};
      CH_MINUS:  r = {1'b1, 6'd6};
      CH_PLUS:   r = {1'b1, 6'd7};
      CH_SEMI:   r = {1'b1, 6'd8};
      CH_STAR:   r = {1'b1, 6'd10};
      default:   r = 7'd0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] clamp16(input logic [32:0] v);
    return (v > 33'd65535) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

// File: sv/lls_core.sv
// ----------------------------------------------------------------------------
// lls_core
// Scanner state and the combinational logic that turns one byte into results.
// ----------------------------------------------------------------------------
module lls_core #(
  parameter int unsigned POSITION_BITS     = 16,
  parameter int unsigned KEYWORD_MAX_CHARS = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  lls_pkg::in_item_t item_i,
  output lls_pkg::batch_t   batch_o
);

  localparam int unsigned P  = POSITION_BITS;
  localparam int unsigned WW = 8 * KEYWORD_MAX_CHARS;

  typedef enum logic [3:0] {
    M_IDLE, M_BANG, M_EQUAL, M_LESS, M_GREATER, M_SLASH, M_COMMENT,
    M_STRING, M_NUM_INT, M_NUM_DOT, M_NUM_FRAC, M_IDENT
  } mode_e;

  mode_e          mode_q, mode_d;
  logic [P-1:0]   pos_q, pos_d;
  logic [P-1:0]   tb_q, tb_d;
  logic [15:0]    line_q, line_d;
  logic [WW-1:0]  wb_q, wb_d;
  logic           tl_q, tl_d;

  lls_pkg::out_item_t [lls_pkg::MaxResults-1:0] res;
  logic [2:0]     n;
  logic           used;
  logic           fin_go;
  logic [P:0]     fin_end;
  logic [P:0]     dot_at;
  logic [P:0]     cur;
  logic [7:0]     c;
  logic [6:0]     sk;

  function automatic lls_pkg::out_item_t mk(input logic [5:0] kind,
                                            input logic [32:0] start,
                                            input logic [32:0] len,
                                            input logic [15:0] line,
                                            input logic eot);
    lls_pkg::out_item_t r;
    r.token_kind    = kind;
    r.start_offset  = lls_pkg::clamp16(start);
    r.token_length  = lls_pkg::clamp16(len);
    r.line_number   = line;
    r.end_of_tokens = eot;
    return r;
  endfunction

  function automatic logic [P:0] ssub(input logic [P:0] a, input logic [P:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

  always_comb begin
    mode_d  = mode_q;
    tb_d    = tb_q;
    line_d  = line_q;
    wb_d    = wb_q;
    tl_d    = tl_q;
    n       = 3'd0;
    res     = '0;
    used    = 1'b1;
    c       = item_i.source_byte;
    cur     = {1'b0, pos_q};
    fin_go  = 1'b0;
    fin_end = '0;
    dot_at  = '0;
    sk      = lls_pkg::single_kind(c);

    unique case (mode_q) inside
      M_BANG, M_EQUAL, M_LESS, M_GREATER: begin
        if (c == lls_pkg::CH_EQUAL) begin
          res[n[1:0]] = mk((mode_q == M_BANG)  ? lls_pkg::K_BANG + 6'd1 :
                           (mode_q == M_EQUAL) ? lls_pkg::K_EQUAL + 6'd1 :
                           (mode_q == M_LESS)  ? lls_pkg::K_LESS + 6'd1 :
                                                 lls_pkg::K_GREATER + 6'd1,
                           33'(tb_q), 33'd2, line_d, 1'b0);
          n = n + 3'd1;
          mode_d = M_IDLE;
        end else begin
          used = 1'b0;
        end
      end
      M_SLASH: begin
        if (c == lls_pkg::CH_SLASH) mode_d = M_COMMENT;
        else used = 1'b0;
      end
      M_COMMENT: begin
        if (c == lls_pkg::CH_NL) begin
          mode_d = M_IDLE;
          used   = 1'b0;
        end
      end
      M_STRING: begin
        if (c == lls_pkg::CH_QUOTE) begin
          res[n[1:0]] = mk(lls_pkg::K_STRING, 33'(tb_q),
                           33'(ssub(cur + 1'b1, {1'b0, tb_q})), line_d, 1'b0);
          n = n + 3'd1;
          mode_d = M_IDLE;
        end else if (c == lls_pkg::CH_NL && line_d != 16'hFFFF) begin
          line_d = line_d + 16'd1;
        end
      end
      M_NUM_INT: begin
        if (c == lls_pkg::CH_DOT) mode_d = M_NUM_DOT;
        else if (!lls_pkg::digit_char(c)) used = 1'b0;
      end
      M_NUM_DOT: begin
        if (lls_pkg::digit_char(c)) mode_d = M_NUM_FRAC;
        else used = 1'b0;
      end
      M_NUM_FRAC: begin
        if (!lls_pkg::digit_char(c)) used = 1'b0;
      end
      M_IDENT: begin
        if (lls_pkg::alpha_char(c) || lls_pkg::digit_char(c)) begin
          if (wb_q[WW-1 -: 8] != 8'd0) tl_d = 1'b1;
          else wb_d = {wb_q[WW-9:0], c};
        end else begin
          used = 1'b0;
        end
      end
      default: begin
        mode_d = M_IDLE;
        used   = 1'b0;
      end
    endcase

    pos_d = (pos_q != '1) ? pos_q + 1'b1 : pos_q;

    // pass 0 closes on an unused byte, pass 1 closes at end of source
    for (int pass = 0; pass < 2; pass++) begin
      fin_go  = (pass == 0) ? !used : item_i.final_byte;
      fin_end = (pass == 0) ? cur : {1'b0, pos_d};
      if (fin_go) begin
        unique case (mode_d) inside
          M_BANG: begin
            res[n[1:0]] = mk(lls_pkg::K_BANG, 33'(tb_d), 33'd1, line_d, 1'b0);
            n = n + 3'd1;
          end
          M_EQUAL: begin
            res[n[1:0]] = mk(lls_pkg::K_EQUAL, 33'(tb_d), 33'd1, line_d, 1'b0);
            n = n + 3'd1;
          end
          M_LESS: begin
            res[n[1:0]] = mk(lls_pkg::K_LESS, 33'(tb_d), 33'd1, line_d, 1'b0);
            n = n + 3'd1;
          end
          M_GREATER: begin
            res[n[1:0]] = mk(lls_pkg::K_GREATER, 33'(tb_d), 33'd1, line_d, 1'b0);
            n = n + 3'd1;
          end
          M_SLASH: begin
            res[n[1:0]] = mk(lls_pkg::K_SLASH, 33'(tb_d), 33'd1, line_d, 1'b0);
            n = n + 3'd1;
          end
          M_STRING: begin
            res[n[1:0]] = mk(lls_pkg::K_UNTERM, 33'(tb_d),
                             33'(ssub(fin_end, {1'b0, tb_d})), line_d, 1'b0);
            n = n + 3'd1;
          end
          M_NUM_INT, M_NUM_FRAC: begin
            res[n[1:0]] = mk(lls_pkg::K_NUMBER, 33'(tb_d),
                             33'(ssub(fin_end, {1'b0, tb_d})), line_d, 1'b0);
            n = n + 3'd1;
          end
          M_NUM_DOT: begin
            // trailing dot splits off as its own token
            dot_at = ssub(fin_end, (P+1)'(1));
            res[n[1:0]] = mk(lls_pkg::K_NUMBER, 33'(tb_d),
                             33'(ssub(dot_at, {1'b0, tb_d})), line_d, 1'b0);
            n = n + 3'd1;
            res[n[1:0]] = mk(lls_pkg::K_DOT, 33'(dot_at), 33'd1, line_d, 1'b0);
            n = n + 3'd1;
          end
          M_IDENT: begin
            res[n[1:0]] = mk(tl_d ? lls_pkg::K_IDENT : lls_pkg::kw_kind(64'(wb_d)),
                             33'(tb_d), 33'(ssub(fin_end, {1'b0, tb_d})), line_d,
                             1'b0);
            n = n + 3'd1;
          end
          default: ;
        endcase
        mode_d = M_IDLE;
      end

      if (pass == 0 && !used) begin
        tb_d = pos_q;
        if (sk[6]) begin
          res[n[1:0]] = mk(sk[5:0], 33'(cur), 33'd1, line_d, 1'b0);
          n = n + 3'd1;
        end else begin
          unique case (c) inside
            lls_pkg::CH_BANG:    mode_d = M_BANG;
            lls_pkg::CH_EQUAL:   mode_d = M_EQUAL;
            lls_pkg::CH_LESS:    mode_d = M_LESS;
            lls_pkg::CH_GREATER: mode_d = M_GREATER;
            lls_pkg::CH_SLASH:   mode_d = M_SLASH;
            lls_pkg::CH_QUOTE:   mode_d = M_STRING;
            lls_pkg::CH_SPACE, lls_pkg::CH_CR, lls_pkg::CH_TAB: ;
            lls_pkg::CH_NL: begin
              if (line_d != 16'hFFFF) line_d = line_d + 16'd1;
            end
            default: begin
              if (lls_pkg::digit_char(c)) begin
                mode_d = M_NUM_INT;
              end else if (lls_pkg::alpha_char(c)) begin
                mode_d = M_IDENT;
                wb_d   = WW'(c);
                tl_d   = 1'b0;
              end else begin
                res[n[1:0]] = mk(lls_pkg::K_BADCHAR, 33'(cur), 33'd1, line_d, 1'b0);
                n = n + 3'd1;
              end
            end
          endcase
        end
      end
    end

    if (item_i.final_byte) begin
      res[n[1:0]] = mk(lls_pkg::K_END, 33'(pos_d), 33'd0, line_d, 1'b1);
      n = n + 3'd1;
      mode_d = M_IDLE;
      pos_d  = '0;
      tb_d   = '0;
      line_d = 16'd1;
      wb_d   = '0;
      tl_d   = 1'b0;
    end
  end

  assign batch_o.items = res;
  assign batch_o.count = n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      pos_q  <= '0;
      tb_q   <= '0;
      line_q <= 16'd1;
      wb_q   <= '0;
      tl_q   <= 1'b0;
    end else if (take_i) begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      tb_q   <= tb_d;
      line_q <= line_d;
      wb_q   <= wb_d;
      tl_q   <= tl_d;
    end
  end

endmodule

// File: sv/lls_obuf.sv
// ----------------------------------------------------------------------------
// lls_obuf
// Result register bank: loads all results of one byte, drains one per cycle while the sink is ready.
// ----------------------------------------------------------------------------
module lls_obuf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  lls_pkg::batch_t    batch_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output lls_pkg::out_item_t out_data_o,
  output logic               in_ready_o
);

  lls_pkg::out_item_t [lls_pkg::MaxResults-1:0] buf_q;
  logic [1:0] head_q;
  logic [2:0] cnt_q;
  logic       pop;

  assign out_valid_o = (cnt_q != 3'd0);
  assign out_data_o  = buf_q[head_q];
  assign pop         = out_valid_o && out_ready_i;
  // free once the last waiting result leaves in this cycle
  assign in_ready_o  = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && out_ready_i);

  always_ff @(posedge clk_i) begin
    if (take_i) buf_q <= batch_i.items;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      cnt_q  <= '0;
    end else if (take_i) begin
      head_q <= '0;
      cnt_q  <= batch_i.count;
    end else if (pop) begin
      head_q <= head_q + 2'd1;
      cnt_q  <= cnt_q - 3'd1;
    end
  end

endmodule

// File: sv/lox_lexical_scanner_top.sv
// ----------------------------------------------------------------------------
// lox_lexical_scanner_top
// Streaming Lox tokenizer: source bytes in, tokens out.
// ----------------------------------------------------------------------------
//   channel | direction | handshake                | payload
//   in      | input     | in_valid_i / in_ready_o  | in_data_i  (in_item_t)
//   out     | output    | out_valid_o/ out_ready_i | out_data_o (out_item_t)
//
// One byte per cycle while the bank is free: the scan logic decides all
// results of a byte in the cycle it is taken and loads them into a four-entry
// result bank. Results drain one per cycle while the sink is ready. A byte with
// several results stalls input till its last leaves; one result never does.
// Reset: scanner idle, position 0, line 1, no results waiting.
// After the final byte the scanner returns to its reset state.
// ----------------------------------------------------------------------------
module lox_lexical_scanner_top #(
  parameter int unsigned POSITION_BITS     = 16,
  parameter int unsigned KEYWORD_MAX_CHARS = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lls_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lls_pkg::out_item_t out_data_o
);

  logic            take;
  lls_pkg::batch_t batch;

  assign take = in_valid_i && in_ready_o;

  lls_core #(
    .POSITION_BITS    (POSITION_BITS),
    .KEYWORD_MAX_CHARS(KEYWORD_MAX_CHARS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .item_i (in_data_i),
    .batch_o(batch)
  );

  lls_obuf u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .batch_i    (batch),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .in_ready_o (in_ready_o)
  );

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (batch.count != 3'd0) |=> out_valid_o)
    else $error("taken results not presented");

  a_final_has_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && in_data_i.final_byte |-> (batch.count != 3'd0) &&
      batch.items[batch.count[1:0] - 2'd1].end_of_tokens)
    else $error("final byte without end token");

  a_eot_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.end_of_tokens |->
      out_data_o.token_kind == lls_pkg::K_END)
    else $error("end flag on a non-end token");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> batch.count <= 3'd4)
    else $error("too many results for one byte");

endmodule
